[hw/rtl/pipt_pkg.sv]
// Shared types and constants for the point-in-polygon test unit.
package pipt_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    // One input beat: a polygon vertex, the query point and the last-vertex mark.
    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord vertex_x;
        t_coord vertex_y;
        logic   last_vertex;
    } t_vertex_beat;

    // One result beat.
    typedef struct packed {
        logic point_inside;
        logic on_boundary;
    } t_result;

    // Operands of one edge test: query Q, edge from A to B.
    typedef struct packed {
        logic   en;
        t_coord qx;
        t_coord qy;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

    // Verdict of one edge test.
    typedef struct packed {
        logic toggle;
        logic hit;
    } t_edge_res;

endpackage

[hw/rtl/pipt_edge.sv]
// Two-stage ray-casting edge test: classify and subtract, then multiply.
module pipt_edge (
    input  logic                i_clk,
    input  logic                i_ld2,
    input  logic                i_ld3,
    input  pipt_pkg::t_edge     i_edge,
    output pipt_pkg::t_edge_res o_res
);
    import pipt_pkg::*;

    logic  vhit;
    logic  straddle;
    logic  a_level;
    logic  b_level;
    logic  between_x;
    logic  n_hit_fix;
    logic  n_tog_fix;
    logic  n_str;

    t_diff r_d1, r_d2, r_d3, r_d4;
    logic  r_str2, r_dy_neg2, r_hit2, r_tog2;

    t_prod r_p1, r_p2;
    logic  r_str3, r_dy_neg3, r_hit3, r_tog3;

    logic  p_gt, p_lt, p_eq;

    always_comb begin
        vhit      = ((i_edge.qx == i_edge.ax) && (i_edge.qy == i_edge.ay)) ||
                    ((i_edge.qx == i_edge.bx) && (i_edge.qy == i_edge.by));
        straddle  = ((i_edge.qy > i_edge.ay) && (i_edge.qy < i_edge.by)) ||
                    ((i_edge.qy < i_edge.ay) && (i_edge.qy > i_edge.by));
        a_level   = (i_edge.ay == i_edge.qy);
        b_level   = (i_edge.by == i_edge.qy);
        between_x = ((i_edge.qx > i_edge.ax) && (i_edge.qx < i_edge.bx)) ||
                    ((i_edge.qx < i_edge.ax) && (i_edge.qx > i_edge.bx));

        n_str     = i_edge.en && !vhit && straddle;
        // horizontal edge through the query, or a vertex hit
        n_hit_fix = i_edge.en && (vhit || (!straddle && a_level && b_level && between_x));
        // one endpoint at query height: count by the other endpoint
        n_tog_fix = i_edge.en && !vhit && !straddle &&
                    ((b_level && !a_level && (i_edge.bx > i_edge.qx) &&
                      (i_edge.ay < i_edge.qy)) ||
                     (a_level && !b_level && (i_edge.ax > i_edge.qx) &&
                      (i_edge.by < i_edge.qy)));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld2) begin
            r_d1      <= t_diff'(i_edge.qy) - t_diff'(i_edge.ay);
            r_d2      <= t_diff'(i_edge.bx) - t_diff'(i_edge.ax);
            r_d3      <= t_diff'(i_edge.qx) - t_diff'(i_edge.ax);
            r_d4      <= t_diff'(i_edge.by) - t_diff'(i_edge.ay);
            r_str2    <= n_str;
            r_dy_neg2 <= (i_edge.by < i_edge.ay);
            r_hit2    <= n_hit_fix;
            r_tog2    <= n_tog_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld3) begin
            r_p1      <= t_prod'(r_d1) * t_prod'(r_d2);
            r_p2      <= t_prod'(r_d3) * t_prod'(r_d4);
            r_str3    <= r_str2;
            r_dy_neg3 <= r_dy_neg2;
            r_hit3    <= r_hit2;
            r_tog3    <= r_tog2;
        end
    end

    always_comb begin
        p_gt = (r_p1 > r_p2);
        p_lt = (r_p1 < r_p2);
        p_eq = (r_p1 == r_p2);
        o_res.hit    = r_hit3 || (r_str3 && p_eq);
        o_res.toggle = r_tog3 || (r_str3 && (r_dy_neg3 ? p_lt : p_gt));
    end

endmodule

[hw/rtl/point_in_polygon_test_unit.sv]
// Streaming point-in-polygon test unit, top level.
//
// Input channel (i_valid / o_stall / i_data): one polygon vertex per beat. The
// beat that opens a polygon also carries the query point, which is latched then;
// query fields of later beats are ignored. A beat with last_vertex set closes
// the polygon: the edge back to the first vertex is tested as well.
// Output channel (o_valid / i_stall / o_data): one result beat per polygon,
// point_inside and on_boundary, in polygon order. Non-last beats give nothing.
// Throughput: one vertex per cycle, sustained while the receiver takes results.
// Each beat runs through an input register, a compare/subtract stage, a multiply
// stage and the accumulate/output register; a polygon's result shows on o_valid
// once its last vertex has passed through them. The two multipliers per edge
// (25 x 25 signed) set the stage boundary; no other loop limits the rate.
// Reset (i_rst_n low, synchronous) empties the pipeline, drops any result and
// re-arms the block to wait for the first vertex of a new polygon.
// While the receiver stalls, the result holds in the output register and
// vertices keep flowing until a second last-vertex beat waits in the multiply
// stage and the two stages behind it fill; only then does o_stall rise.
module point_in_polygon_test_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  pipt_pkg::t_vertex_beat i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output pipt_pkg::t_result      o_data
);
    import pipt_pkg::*;

    // polygon context
    logic   r_mid_polygon;
    t_coord r_held_qx, r_held_qy;
    t_coord r_first_vx, r_first_vy;
    t_coord r_prev_vx, r_prev_vy;

    // pipeline control
    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;
    logic r_open1, r_open2, r_open3;
    t_edge r_edge_in1, r_edge_close1;

    // accumulators and result
    logic    r_parity, r_boundary;
    logic    r_out_valid;
    t_result r_out;

    logic  accept;
    logic  out_free, adv3, rdy3, rdy2, rdy1;
    t_edge n_edge_in, n_edge_close;
    t_coord q_x, q_y, f_x, f_y;
    t_edge_res res_in, res_close;
    logic  n_parity, n_boundary;

    // Ready chain: a stage takes new data when it is empty or moves on.
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        adv3     = r_v3 && (!r_last3 || out_free);
        rdy3     = !r_v3 || adv3;
        rdy2     = !r_v2 || rdy3;
        rdy1     = !r_v1 || rdy2;
        accept   = i_valid && rdy1;
    end

    assign o_stall = !rdy1;

    // Edge operands: the incoming edge from the previous vertex, and the closing
    // edge back to the first vertex on the last beat.
    always_comb begin
        q_x = r_mid_polygon ? r_held_qx  : i_data.query_x;
        q_y = r_mid_polygon ? r_held_qy  : i_data.query_y;
        f_x = r_mid_polygon ? r_first_vx : i_data.vertex_x;
        f_y = r_mid_polygon ? r_first_vy : i_data.vertex_y;

        n_edge_in.en = r_mid_polygon;
        n_edge_in.qx = q_x;
        n_edge_in.qy = q_y;
        n_edge_in.ax = r_prev_vx;
        n_edge_in.ay = r_prev_vy;
        n_edge_in.bx = i_data.vertex_x;
        n_edge_in.by = i_data.vertex_y;

        n_edge_close.en = i_data.last_vertex;
        n_edge_close.qx = q_x;
        n_edge_close.qy = q_y;
        n_edge_close.ax = i_data.vertex_x;
        n_edge_close.ay = i_data.vertex_y;
        n_edge_close.bx = f_x;
        n_edge_close.by = f_y;
    end

    // Control state: polygon phase, stage valids, result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_polygon <= 1'b0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_parity      <= 1'b0;
            r_boundary    <= 1'b0;
        end else begin
            if (accept) begin
                r_mid_polygon <= !i_data.last_vertex;
            end
            if (rdy1) begin
                r_v1 <= accept;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (adv3) begin
                r_parity   <= n_parity;
                r_boundary <= n_boundary;
            end
            if (adv3 && r_last3) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: polygon context and stage data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_mid_polygon) begin
                r_held_qx  <= i_data.query_x;
                r_held_qy  <= i_data.query_y;
                r_first_vx <= i_data.vertex_x;
                r_first_vy <= i_data.vertex_y;
            end
            r_prev_vx <= i_data.vertex_x;
            r_prev_vy <= i_data.vertex_y;
        end
        if (rdy1) begin
            r_edge_in1    <= n_edge_in;
            r_edge_close1 <= n_edge_close;
            r_last1       <= i_data.last_vertex;
            r_open1       <= !r_mid_polygon;
        end
        if (rdy2) begin
            r_last2 <= r_last1;
            r_open2 <= r_open1;
        end
        if (rdy3) begin
            r_last3 <= r_last2;
            r_open3 <= r_open2;
        end
        if (adv3 && r_last3) begin
            r_out.point_inside <= n_parity || n_boundary;
            r_out.on_boundary  <= n_boundary;
        end
    end

    pipt_edge u_edge_in (
        .i_clk  (i_clk),
        .i_ld2  (rdy2),
        .i_ld3  (rdy3),
        .i_edge (r_edge_in1),
        .o_res  (res_in)
    );

    pipt_edge u_edge_close (
        .i_clk  (i_clk),
        .i_ld2  (rdy2),
        .i_ld3  (rdy3),
        .i_edge (r_edge_close1),
        .o_res  (res_close)
    );

    // Fold both edge verdicts; a polygon's first vertex restarts the count.
    always_comb begin
        n_parity   = (r_open3 ? 1'b0 : r_parity) ^ res_in.toggle ^ res_close.toggle;
        n_boundary = (r_open3 ? 1'b0 : r_boundary) | res_in.hit | res_close.hit;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[hw/rtl/pipt_checker.sv]
// Port-level checks for the point-in-polygon test unit, bound to the top level.
module pipt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input pipt_pkg::t_result o_data
);

    // Hold a stalled result beat unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // A boundary point always reports inside.
    a_boundary_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.on_boundary |-> o_data.point_inside)
        else $error("boundary result without inside flag");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // With the output free, the input side never stalls (one last beat fits in flight).
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output is empty");

endmodule

bind point_in_polygon_test_unit pipt_checker u_pipt_checker (.*);
